### rtl/ljge_pkg.sv
// ----------------------------------------------------------------------------
// Lennard-Jones group energy package
// Transfer types, register map, reset values and state codes shared by the
// pair-energy block and its register file.
// ----------------------------------------------------------------------------
package ljge_pkg;

    // One atom as it arrives on the input channel.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               frame_end;
    } ljge_in_t;

    // One frame result as it leaves on the output channel.
    typedef struct packed {
        logic signed [63:0] frame_energy;
        logic [31:0]        frame_number;
        logic               saturated;
    } ljge_out_t;

    // Configuration port geometry: registers lie every eight bytes.
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    // Register indexes (paddr[5:3]).
    typedef enum logic [2:0] {
        REG_COUNT_A   = 3'd0,
        REG_COUNT_B   = 3'd1,
        REG_CUTOFF_SQ = 3'd2,
        REG_SIGMA_SQ  = 3'd3,
        REG_FOUR_EPS  = 3'd4
    } reg_idx_t;

    // Register reset values.
    localparam logic [10:0] COUNT_A_RST   = 11'd572;
    localparam logic [15:0] COUNT_B_RST   = 16'd1452;
    localparam logic [63:0] CUTOFF_SQ_RST = 64'd446848397476;
    localparam logic [63:0] SIGMA_SQ_RST  = 64'd498544728;
    localparam logic [31:0] FOUR_EPS_RST  = 32'd50989852;

    // Atom counter width and its saturation value.
    localparam int               CNT_W   = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Accumulator limits.
    localparam logic signed [63:0] ENERGY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ENERGY_MIN = 64'sh8000_0000_0000_0000;

    // Operations carried out on the shared multiplier.
    typedef enum logic [1:0] {
        OP_Q_Q   = 2'd0,
        OP_Q2_Q  = 2'd1,
        OP_Q3_Q3 = 2'd2,
        OP_EPS   = 2'd3
    } mul_op_t;

    // Sequencer states, one-hot.
    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_RD   = 10'b00_0000_0010,
        S_DIF  = 10'b00_0000_0100,
        S_SQ   = 10'b00_0000_1000,
        S_CHK  = 10'b00_0001_0000,
        S_DIV  = 10'b00_0010_0000,
        S_MUL  = 10'b00_0100_0000,
        S_DIFQ = 10'b00_1000_0000,
        S_ACC  = 10'b01_0000_0000,
        S_FIN  = 10'b10_0000_0000
    } state_t;

endpackage

### rtl/ljge_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ljge_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                                          aclk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/lennard_jones_group_energy.sv
// ----------------------------------------------------------------------------
// Lennard-Jones group energy
// 12-6 pair energy with cutoff between two atom groups, fixed point.
// ----------------------------------------------------------------------------
// Atoms of a frame arrive one per transfer. The first count_a atoms, up to
// MAX_GROUP_A, are written to the group-A RAM. Each second-group atom is then
// paired with every stored atom, one pair at a time on a single 32x32
// multiplier: a pair outside the cutoff takes a RAM read, the differences,
// three squares and a compare, and a pair inside it adds the bit-serial
// division for sigma_sq / r^2 and four multiplications. The block takes no
// new atom until it is through with all pairs of the current one; an atom
// flagged frame_end then hands over the frame result, and waits while the
// previous frame result still waits on the output. Atoms after the second
// group are passed by without pairing. New atoms are accepted while an
// earlier frame result waits on the output, up to the next frame end.

module lennard_jones_group_energy #(
    parameter int MAX_GROUP_A = 1024,
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ljge_pkg::PADDR_W-1:0]  paddr,
    input  logic [ljge_pkg::PDATA_W-1:0]  pwdata,
    output logic [ljge_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ljge_pkg::ljge_in_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ljge_pkg::ljge_out_t           m_data
);
    import ljge_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int AW = (MAX_GROUP_A > 1) ? $clog2(MAX_GROUP_A) : 1;
    localparam int NW = $clog2(MAX_GROUP_A + 1);
    localparam int SW = 3 * COORD_WIDTH;
    localparam logic [CNT_W-1:0] MAX_A = CNT_W'(MAX_GROUP_A);

    // Configuration registers.
    logic [10:0] count_a_reg;
    logic [15:0] count_b_reg;
    logic [63:0] cutoff_reg;
    logic [63:0] sigma_reg;
    logic [31:0] four_eps_reg;
    reg_idx_t    reg_sel;
    logic        cfg_wr;

    // Control state.
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [63:0] energy_reg, energy_next;
    logic             sat_reg, sat_next;
    logic [31:0]      frame_reg, frame_next;
    logic             m_valid_reg, m_valid_next;
    logic [NW-1:0]    ptr_reg, ptr_next;
    logic [2:0]       step_reg, step_next;
    logic [5:0]       div_cnt_reg, div_cnt_next;
    mul_op_t          op_reg, op_next;

    // Datapath registers.
    ljge_out_t        m_data_reg, m_data_next;
    logic [CW-1:0]    bx_reg, bx_next, by_reg, by_next, bz_reg, bz_next;
    logic             fe_reg, fe_next;
    logic [NW-1:0]    na_reg, na_next;
    logic [31:0]      dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic [63:0]      prod_reg, prod_next;
    logic [1:0]       sh_reg, sh_next;
    logic [65:0]      r2_reg, r2_next;
    logic [63:0]      rem_reg, rem_next, lo_reg, lo_next;
    logic [63:0]      q_reg, q_next, q2_reg, q2_next, q3_reg, q3_next;
    logic [63:0]      q6_reg, q6_next, diff_reg, diff_next, mag_reg, mag_next;
    logic             neg_reg, neg_next, ovf_reg, ovf_next;
    logic [127:0]     acc_reg, acc_next;

    // Combinational helpers.
    logic             ram_we;
    logic [SW-1:0]    ram_rdata;
    logic [CW-1:0]    ax, ay, az;
    logic signed [CW:0] ddx, ddy, ddz, mdx, mdy, mdz;
    logic [CNT_W-1:0] ca_ext, na_full, b_end;
    logic             in_b;
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      word_a, word_b;
    logic [127:0]     acc_sum;
    logic [63:0]      mres;
    logic             movf;
    logic [63:0]      rem_sh;
    logic signed [65:0] e_ext, e_sum;
    logic             pair_done;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[5:3]);
    assign cfg_wr  = psel & penable & pwrite;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_a_reg  <= COUNT_A_RST;
            count_b_reg  <= COUNT_B_RST;
            cutoff_reg   <= CUTOFF_SQ_RST;
            sigma_reg    <= SIGMA_SQ_RST;
            four_eps_reg <= FOUR_EPS_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_COUNT_A:   count_a_reg  <= pwdata[10:0];
                REG_COUNT_B:   count_b_reg  <= pwdata[15:0];
                REG_CUTOFF_SQ: cutoff_reg   <= pwdata;
                REG_SIGMA_SQ:  sigma_reg    <= pwdata;
                REG_FOUR_EPS:  four_eps_reg <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (reg_sel)
            REG_COUNT_A:   prdata = 64'(count_a_reg);
            REG_COUNT_B:   prdata = 64'(count_b_reg);
            REG_CUTOFF_SQ: prdata = cutoff_reg;
            REG_SIGMA_SQ:  prdata = sigma_reg;
            REG_FOUR_EPS:  prdata = 64'(four_eps_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Group-A store
    // ------------------------------------------------------------------------
    ljge_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_GROUP_A)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata ({s_data.pos_x[CW-1:0], s_data.pos_y[CW-1:0], s_data.pos_z[CW-1:0]}),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Stored atom and its coordinate differences to the current atom.
    assign ax  = ram_rdata[3*CW-1:2*CW];
    assign ay  = ram_rdata[2*CW-1:CW];
    assign az  = ram_rdata[CW-1:0];
    assign ddx = $signed({ax[CW-1], ax}) - $signed({bx_reg[CW-1], bx_reg});
    assign ddy = $signed({ay[CW-1], ay}) - $signed({by_reg[CW-1], by_reg});
    assign ddz = $signed({az[CW-1], az}) - $signed({bz_reg[CW-1], bz_reg});
    assign mdx = ddx[CW] ? -ddx : ddx;
    assign mdy = ddy[CW] ? -ddy : ddy;
    assign mdz = ddz[CW] ? -ddz : ddz;

    // Group bounds for the atom on the input.
    assign ca_ext  = CNT_W'(count_a_reg);
    assign na_full = (ca_ext > MAX_A) ? MAX_A : ca_ext;
    assign b_end   = ca_ext + CNT_W'(count_b_reg);
    assign in_b    = (cnt_reg >= ca_ext) && (cnt_reg < b_end);

    // ------------------------------------------------------------------------
    // Shared multiplier: squares, then 64x64 products in four partial products
    // ------------------------------------------------------------------------
    always_comb begin
        case (op_reg)
            OP_Q_Q:   begin word_a = q_reg;               word_b = q_reg;    end
            OP_Q2_Q:  begin word_a = q2_reg;              word_b = q_reg;    end
            OP_Q3_Q3: begin word_a = q3_reg;              word_b = q3_reg;   end
            default:  begin word_a = 64'(four_eps_reg);   word_b = diff_reg; end
        endcase
        if (state_reg == S_SQ) begin
            case (step_reg[1:0])
                2'd0:    mul_a = dx_reg;
                2'd1:    mul_a = dy_reg;
                default: mul_a = dz_reg;
            endcase
            mul_b = mul_a;
        end else begin
            mul_a = step_reg[1] ? word_a[63:32] : word_a[31:0];
            mul_b = step_reg[0] ? word_b[63:32] : word_b[31:0];
        end
    end

    assign prod_next = 64'(mul_a) * 64'(mul_b);
    assign sh_next   = 2'(step_reg[1]) + 2'(step_reg[0]);
    assign acc_sum   = acc_reg + ({64'd0, prod_reg} << {sh_reg, 5'd0});
    assign mres      = acc_sum[95:32];
    assign movf      = acc_sum[127:96] != 32'd0;
    assign rem_sh    = {rem_reg[62:0], lo_reg[63]};
    assign e_ext     = 66'(energy_reg);
    assign e_sum     = neg_reg ? (e_ext - $signed({2'b00, mag_reg}))
                               : (e_ext + $signed({2'b00, mag_reg}));

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        energy_next  = energy_reg;
        sat_next     = sat_reg;
        frame_next   = frame_reg;
        m_valid_next = m_valid_reg;
        ptr_next     = ptr_reg;
        step_next    = step_reg;
        div_cnt_next = div_cnt_reg;
        op_next      = op_reg;
        m_data_next  = m_data_reg;
        bx_next      = bx_reg;
        by_next      = by_reg;
        bz_next      = bz_reg;
        fe_next      = fe_reg;
        na_next      = na_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        dz_next      = dz_reg;
        r2_next      = r2_reg;
        rem_next     = rem_reg;
        lo_next      = lo_reg;
        q_next       = q_reg;
        q2_next      = q2_reg;
        q3_next      = q3_reg;
        q6_next      = q6_reg;
        diff_next    = diff_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        ovf_next     = ovf_reg;
        acc_next     = acc_reg;
        ram_we       = 1'b0;
        pair_done    = 1'b0;

        // Output register empties when its transfer completes.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            // Take an atom: store it, start its pairing sweep, or pass it by.
            S_IDLE: begin
                if (s_valid) begin
                    cnt_next = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
                    fe_next  = s_data.frame_end;
                    bx_next  = s_data.pos_x[CW-1:0];
                    by_next  = s_data.pos_y[CW-1:0];
                    bz_next  = s_data.pos_z[CW-1:0];
                    if (cnt_reg < na_full) begin
                        ram_we     = 1'b1;
                        state_next = s_data.frame_end ? S_FIN : S_IDLE;
                    end else if (in_b && (na_full != '0)) begin
                        ptr_next   = '0;
                        na_next    = na_full[NW-1:0];
                        state_next = S_RD;
                    end else begin
                        state_next = s_data.frame_end ? S_FIN : S_IDLE;
                    end
                end
            end

            // RAM read in flight.
            S_RD: begin
                state_next = S_DIF;
            end

            // Absolute coordinate differences.
            S_DIF: begin
                dx_next    = 32'(mdx[CW-1:0]);
                dy_next    = 32'(mdy[CW-1:0]);
                dz_next    = 32'(mdz[CW-1:0]);
                step_next  = '0;
                r2_next    = '0;
                state_next = S_SQ;
            end

            // Three squares summed into r^2 with room for the carries.
            S_SQ: begin
                step_next = step_reg + 1'b1;
                if (step_reg != 3'd0) begin
                    r2_next = r2_reg + 66'(prod_reg);
                end
                if (step_reg == 3'd3) begin
                    state_next = S_CHK;
                end
            end

            // Cutoff, saturation, zero distance and quotient overflow checks.
            S_CHK: begin
                if ((r2_reg[65:64] != 2'd0) || (r2_reg[63:0] >= cutoff_reg) || sat_reg) begin
                    pair_done = 1'b1;
                end else if (r2_reg[63:0] == 64'd0) begin
                    energy_next = ENERGY_MAX;
                    sat_next    = 1'b1;
                    pair_done   = 1'b1;
                end else if ({32'd0, sigma_reg[63:32]} >= r2_reg[63:0]) begin
                    energy_next = ENERGY_MAX;
                    sat_next    = 1'b1;
                    pair_done   = 1'b1;
                end else begin
                    rem_next     = {32'd0, sigma_reg[63:32]};
                    lo_next      = {sigma_reg[31:0], 32'd0};
                    q_next       = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end

            // Restoring division, one quotient bit a cycle.
            S_DIV: begin
                lo_next      = {lo_reg[62:0], 1'b0};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (rem_reg[63] || (rem_sh >= r2_reg[63:0])) begin
                    rem_next = rem_sh - r2_reg[63:0];
                    q_next   = {q_reg[62:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[62:0], 1'b0};
                end
                if (div_cnt_reg == 6'd63) begin
                    op_next    = OP_Q_Q;
                    step_next  = '0;
                    acc_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_MUL;
                end
            end

            // Q32.32 products: partial products issued, then accumulated.
            S_MUL: begin
                step_next = step_reg + 1'b1;
                if (step_reg != 3'd0) begin
                    acc_next = acc_sum;
                end
                if (step_reg == 3'd4) begin
                    step_next = '0;
                    acc_next  = '0;
                    case (op_reg)
                        OP_Q_Q: begin
                            q2_next  = mres;
                            ovf_next = ovf_reg | movf;
                            op_next  = OP_Q2_Q;
                        end
                        OP_Q2_Q: begin
                            q3_next  = mres;
                            ovf_next = ovf_reg | movf;
                            op_next  = OP_Q3_Q3;
                        end
                        OP_Q3_Q3: begin
                            q6_next = mres;
                            if (ovf_reg || movf) begin
                                energy_next = ENERGY_MAX;
                                sat_next    = 1'b1;
                                pair_done   = 1'b1;
                            end else begin
                                state_next = S_DIFQ;
                            end
                        end
                        default: begin
                            mag_next   = mres;
                            state_next = S_ACC;
                        end
                    endcase
                end
            end

            // Signed difference q^6 - q^3 as sign and magnitude.
            S_DIFQ: begin
                neg_next   = q6_reg < q3_reg;
                diff_next  = (q6_reg < q3_reg) ? (q3_reg - q6_reg) : (q6_reg - q3_reg);
                op_next    = OP_EPS;
                step_next  = '0;
                acc_next   = '0;
                state_next = S_MUL;
            end

            // Saturating accumulation.
            S_ACC: begin
                pair_done = 1'b1;
                if (!neg_reg && (mag_reg[63] || (e_sum[65:63] != {3{e_sum[63]}}))) begin
                    energy_next = ENERGY_MAX;
                    sat_next    = 1'b1;
                end else if (neg_reg && (e_sum[65:63] != {3{e_sum[63]}})) begin
                    energy_next = ENERGY_MIN;
                    sat_next    = 1'b1;
                end else begin
                    energy_next = e_sum[63:0];
                end
            end

            // Hand the frame result to the output register and clear the frame.
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.frame_energy = energy_reg;
                    m_data_next.frame_number = frame_reg;
                    m_data_next.saturated    = sat_reg;
                    m_valid_next             = 1'b1;
                    frame_next               = frame_reg + 1'b1;
                    energy_next              = '0;
                    sat_next                 = 1'b0;
                    cnt_next                 = '0;
                    state_next               = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Move to the next stored atom or finish the current atom.
        if (pair_done) begin
            ptr_next = ptr_reg + 1'b1;
            if (NW'(ptr_reg + 1'b1) < na_reg) begin
                state_next = S_RD;
            end else begin
                state_next = fe_reg ? S_FIN : S_IDLE;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            energy_reg  <= '0;
            sat_reg     <= 1'b0;
            frame_reg   <= '0;
            m_valid_reg <= 1'b0;
            ptr_reg     <= '0;
            step_reg    <= '0;
            div_cnt_reg <= '0;
            op_reg      <= OP_Q_Q;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            energy_reg  <= energy_next;
            sat_reg     <= sat_next;
            frame_reg   <= frame_next;
            m_valid_reg <= m_valid_next;
            ptr_reg     <= ptr_next;
            step_reg    <= step_next;
            div_cnt_reg <= div_cnt_next;
            op_reg      <= op_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        bz_reg     <= bz_next;
        fe_reg     <= fe_next;
        na_reg     <= na_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        dz_reg     <= dz_next;
        prod_reg   <= prod_next;
        sh_reg     <= sh_next;
        r2_reg     <= r2_next;
        rem_reg    <= rem_next;
        lo_reg     <= lo_next;
        q_reg      <= q_next;
        q2_reg     <= q2_next;
        q3_reg     <= q3_next;
        q6_reg     <= q6_next;
        diff_reg   <= diff_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        ovf_reg    <= ovf_next;
        acc_reg    <= acc_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
